// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Property shorthands for the checker module of the lookup cache.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk_i
`define HOL_ASSERT_IMP(lbl, clk_i, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk_i
`define HOL_ASSERT_NXT(lbl, clk_i, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hol_pkg.sv
// ----------------------------------------------------------------------------
// hol_pkg
// Shared types and constants of the hashed opcode lookup cache.
// ----------------------------------------------------------------------------
package hol_pkg;

  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int CNT_W = 32;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL   = 2'd2;

  // Fibonacci hash constants
  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9e37_79b1;
  localparam int               HASH_FOLD = 16;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RESOLVE
  } bk_state_t;

endpackage

// File: rtl/hol_ram.sv
// ----------------------------------------------------------------------------
// hol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/hol_fifo.sv
// ----------------------------------------------------------------------------
// hol_fifo
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hol_fifo #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output hol_pkg::fifo_stat_t stat
);

  import hol_pkg::*;

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  assign pop_data   = entry[rd_ptr];
  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);

endmodule

// File: rtl/hol_front.sv
// ----------------------------------------------------------------------------
// hol_front
// Accepts requests, hashes the opcode into a slot index and queues them.
// ----------------------------------------------------------------------------
module hol_front #(
  parameter int SLOT_COUNT    = 4096,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hol_pkg::OP_W-1:0]      operation,
  input  logic [hol_pkg::KEY_W-1:0]     opcode,
  input  logic [PAYLOAD_WIDTH-1:0]      payload,
  input  logic                          clearing,
  input  hol_pkg::fifo_stat_t           fifo_stat,
  output logic                          push,
  output logic [hol_pkg::OP_W-1:0]      push_op,
  output logic [hol_pkg::KEY_W-1:0]     push_key,
  output logic [$clog2(SLOT_COUNT)-1:0] push_idx,
  output logic [PAYLOAD_WIDTH-1:0]      push_data
);

  import hol_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic                     s1_valid;
  logic [OP_W-1:0]          s1_op;
  logic [KEY_W-1:0]         s1_key;
  logic [PAYLOAD_WIDTH-1:0] s1_data;
  logic [KEY_W-1:0]         s1_prod;
  logic [KEY_W-1:0]         prod_next;
  logic [KEY_W-1:0]         mixed;
  logic                     accept;

  // Low word of the hash product
  assign prod_next = opcode * HASH_MULT;

  // Hold new requests while clearing or while the queue backs up
  assign in_stall = clearing || (s1_valid && fifo_stat.full);
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid && !fifo_stat.full;

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= operation;
      s1_key  <= opcode;
      s1_data <= payload;
      s1_prod <= prod_next;
    end
  end

  // Fold the product and mask to a slot index
  assign mixed     = s1_prod ^ (s1_prod >> HASH_FOLD);
  assign push_idx  = IDX_W'(mixed & KEY_W'(SLOT_COUNT - 1));
  assign push_op   = s1_op;
  assign push_key  = s1_key;
  assign push_data = s1_data;

endmodule

// File: rtl/hol_back.sv
// ----------------------------------------------------------------------------
// hol_back
// Clears the slot table, resolves queued requests and keeps the counters.
// ----------------------------------------------------------------------------
module hol_back #(
  parameter int SLOT_COUNT    = 4096,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cache_en,
  input  hol_pkg::fifo_stat_t           fifo_stat,
  output logic                          pop,
  input  logic [hol_pkg::OP_W-1:0]      head_op,
  input  logic [hol_pkg::KEY_W-1:0]     head_key,
  input  logic [$clog2(SLOT_COUNT)-1:0] head_idx,
  input  logic [PAYLOAD_WIDTH-1:0]      head_data,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic                          collision,
  output logic                          stored,
  output logic [PAYLOAD_WIDTH-1:0]      payload_out,
  output logic [hol_pkg::CNT_W-1:0]     hit_count,
  output logic [hol_pkg::CNT_W-1:0]     miss_count,
  output logic [hol_pkg::CNT_W-1:0]     collision_count
);

  import hol_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int ENT_W = 1 + KEY_W + PAYLOAD_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  bk_state_t state, state_next;

  logic [IDX_W-1:0]         clr_cnt;
  logic [OP_W-1:0]          cur_op;
  logic [KEY_W-1:0]         cur_key;
  logic [IDX_W-1:0]         cur_idx;
  logic [PAYLOAD_WIDTH-1:0] cur_data;
  logic [CNT_W-1:0]         hits_total;
  logic [CNT_W-1:0]         misses_total;
  logic [CNT_W-1:0]         colls_total;

  logic                     take;
  logic                     load;
  logic                     ram_we;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [ENT_W-1:0]         ram_rdata;

  logic                     rd_valid;
  logic [KEY_W-1:0]         rd_tag;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic                     is_count;
  logic                     is_store;
  logic                     hit_next;
  logic                     coll_next;
  logic                     miss_next;
  logic [PAYLOAD_WIDTH-1:0] pout_next;
  logic [CNT_W-1:0]         hits_next;
  logic [CNT_W-1:0]         misses_next;
  logic [CNT_W-1:0]         colls_next;

  hol_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_idx),
    .rdata (ram_rdata)
  );

  // Take a request only when the result register will be free
  assign take = !fifo_stat.empty && (!out_valid || !out_stall);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_cnt == LAST_IDX) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (take) begin
          state_next = BK_RESOLVE;
        end
      end
      BK_RESOLVE: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  // Decode the slot entry and resolve the request
  assign rd_valid  = ram_rdata[ENT_W-1];
  assign rd_tag    = ram_rdata[PAYLOAD_WIDTH +: KEY_W];
  assign rd_pay    = ram_rdata[PAYLOAD_WIDTH-1:0];
  assign is_count  = (cur_op == OP_LOOKUP) || (cur_op == OP_INSERT);
  assign is_store  = cache_en && ((cur_op == OP_INSERT) || (cur_op == OP_FILL));
  assign hit_next  = is_count && cache_en && rd_valid && (rd_tag == cur_key);
  assign coll_next = is_count && cache_en && rd_valid && (rd_tag != cur_key);
  assign miss_next = is_count && !hit_next;
  assign pout_next = is_store ? cur_data : (hit_next ? rd_pay : '0);

  assign hits_next   = hits_total + CNT_W'(hit_next);
  assign misses_next = misses_total + CNT_W'(miss_next);
  assign colls_next  = colls_total + CNT_W'(coll_next);

  // Outputs per state
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = {1'b1, cur_key, cur_data};
    pop       = 1'b0;
    load      = 1'b0;
    clearing  = 1'b0;
    case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        pop    = take;
        ram_re = take;
      end
      BK_RESOLVE: begin
        load   = 1'b1;
        ram_we = is_store;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      clr_cnt      <= '0;
      hits_total   <= '0;
      misses_total <= '0;
      colls_total  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (load) begin
        hits_total   <= hits_next;
        misses_total <= misses_next;
        colls_total  <= colls_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the popped request
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op   <= head_op;
      cur_key  <= head_key;
      cur_idx  <= head_idx;
      cur_data <= head_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      hit             <= hit_next;
      collision       <= coll_next;
      stored          <= is_store;
      payload_out     <= pout_next;
      hit_count       <= hits_next;
      miss_count      <= misses_next;
      collision_count <= colls_next;
    end
  end

endmodule

// File: rtl/hashed_opcode_lookup_cache_unit.sv
// A request passes the hash stage, the queue, then the slot read and resolve in the back end.
// The back end resolves one request at a time, reading then writing the slot RAM before it takes the next.
// Reset: synchronous; clears counters and queue and sets cache_enable to 1, then a clearing pass
// writes every slot invalid while in_stall stays high.
// Configuration writes are taken at any time (cfg_ready is always high).
// ----------------------------------------------------------------------------
// hashed_opcode_lookup_cache_unit
// Direct-mapped opcode cache with Fibonacci-hashed slots and hit/miss counters.
// ----------------------------------------------------------------------------
module hashed_opcode_lookup_cache_unit #(
  parameter int SLOT_COUNT    = 4096,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [hol_pkg::OP_W-1:0]  operation,
  input  logic [hol_pkg::KEY_W-1:0] opcode,
  input  logic [PAYLOAD_WIDTH-1:0]  payload,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic                      collision,
  output logic                      stored,
  output logic [PAYLOAD_WIDTH-1:0]  payload_out,
  output logic [hol_pkg::CNT_W-1:0] hit_count,
  output logic [hol_pkg::CNT_W-1:0] miss_count,
  output logic [hol_pkg::CNT_W-1:0] collision_count
);

  import hol_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int REQ_W = OP_W + KEY_W + IDX_W + PAYLOAD_WIDTH;

  logic                     cache_enable;
  logic                     clearing;
  fifo_stat_t               fifo_stat;
  logic                     push;
  logic                     pop;
  logic [OP_W-1:0]          push_op;
  logic [KEY_W-1:0]         push_key;
  logic [IDX_W-1:0]         push_idx;
  logic [PAYLOAD_WIDTH-1:0] push_data;
  logic [REQ_W-1:0]         head;

  // Enable register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      cache_enable <= cfg_data;
    end
  end

  hol_front #(
    .SLOT_COUNT    (SLOT_COUNT),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .opcode    (opcode),
    .payload   (payload),
    .clearing  (clearing),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_op   (push_op),
    .push_key  (push_key),
    .push_idx  (push_idx),
    .push_data (push_data)
  );

  hol_fifo #(
    .WIDTH (REQ_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_op, push_key, push_idx, push_data}),
    .pop       (pop),
    .pop_data  (head),
    .stat      (fifo_stat)
  );

  hol_back #(
    .SLOT_COUNT    (SLOT_COUNT),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cache_en        (cache_enable),
    .fifo_stat       (fifo_stat),
    .pop             (pop),
    .head_op         (head[REQ_W-1 -: OP_W]),
    .head_key        (head[IDX_W + PAYLOAD_WIDTH +: KEY_W]),
    .head_idx        (head[PAYLOAD_WIDTH +: IDX_W]),
    .head_data       (head[PAYLOAD_WIDTH-1:0]),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .collision       (collision),
    .stored          (stored),
    .payload_out     (payload_out),
    .hit_count       (hit_count),
    .miss_count      (miss_count),
    .collision_count (collision_count)
  );

endmodule

// File: rtl/hol_checker.sv
// ----------------------------------------------------------------------------
// hol_checker
// Port-level checks of the lookup cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hol_checker #(
  parameter int PAYLOAD_WIDTH = 64
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      hit,
  input logic                      collision,
  input logic [PAYLOAD_WIDTH-1:0]  payload_out,
  input logic [hol_pkg::CNT_W-1:0] hit_count,
  input logic [hol_pkg::CNT_W-1:0] miss_count
);

  import hol_pkg::*;

  // A stalled result holds its value and counters
  `HOL_ASSERT_NXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(payload_out) && $stable(hit_count) && $stable(miss_count), "stalled result changed")

  // A hit never also reports a collision
  `HOL_ASSERT_IMP(a_hit_no_coll, clk, rst, out_valid && hit, !collision, "hit and collision both set")

  // Reset empties the result and starts the clearing pass
  `HOL_ASSERT_NXT(a_reset_state, clk, 1'b0, rst, !out_valid && in_stall, "bad state after reset")

endmodule

bind hashed_opcode_lookup_cache_unit hol_checker #(
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_hol_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Opcode lookup cache testbench
// Drives lookup, insert and fill requests into the hashed opcode cache and
// checks every response against an in-bench shadow of the slot table and
// counters. Covers corner opcodes and payloads, slot collisions, the disabled
// mode, long output back-pressure and random tracer-style traffic.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hol_pkg::*;

  localparam int SLOTS       = 4096;
  localparam int PAYLOAD_W   = 64;
  localparam int LATENCY     = 4;
  localparam int IDLE_MAX    = 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 26;

  // Operation code the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    bit                   hit;
    bit                   collision;
    bit                   stored;
    bit [PAYLOAD_W-1:0]   payload_out;
    bit [CNT_W-1:0]       hits;
    bit [CNT_W-1:0]       misses;
    bit [CNT_W-1:0]       collisions;
  } cache_outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      operation;
  logic [KEY_W-1:0]     opcode;
  logic [PAYLOAD_W-1:0] payload;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic                 collision;
  logic                 stored;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [CNT_W-1:0]     collision_count;

  // Shadow of the slot table, counters and enable register
  bit                   slot_live [SLOTS];
  bit [KEY_W-1:0]       slot_key  [SLOTS];
  bit [PAYLOAD_W-1:0]   slot_data [SLOTS];
  bit [CNT_W-1:0]       hits_total;
  bit [CNT_W-1:0]       misses_total;
  bit [CNT_W-1:0]       collisions_total;
  bit                   enable_shadow;

  cache_outcome_t       outcomes_due[$];
  cache_outcome_t       last_outcome;
  logic [KEY_W-1:0]     key_pool [POOL_SIZE];

  bit                   tx_no_idle;
  bit                   rx_no_idle;
  int                   rx_hold_cycles;
  int                   errors;
  int                   requests_sent;
  int                   results_checked;
  int                   hits_checked;
  int                   collisions_checked;
  int                   stores_checked;
  int                   enable_writes;
  int                   long_holds;

  hashed_opcode_lookup_cache_unit #(
    .SLOT_COUNT    (SLOTS),
    .PAYLOAD_WIDTH (PAYLOAD_W)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .opcode          (opcode),
    .payload         (payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .collision       (collision),
    .stored          (stored),
    .payload_out     (payload_out),
    .hit_count       (hit_count),
    .miss_count      (miss_count),
    .collision_count (collision_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fibonacci hash: multiply mod 2^32, fold the upper half down, mask
  function automatic int slot_of(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] mixed;
    mixed = key * HASH_MULT;
    mixed = mixed ^ (mixed >> HASH_FOLD);
    return int'(mixed) & (SLOTS - 1);
  endfunction

  // Pick a different key that lands on the same slot
  function automatic logic [KEY_W-1:0] partner_of(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] cand;
    do
      cand = $urandom;
    while (cand == key || slot_of(cand) != slot_of(key));
    return cand;
  endfunction

  // Apply one request to the shadow table and return the response it owes
  function automatic cache_outcome_t cache_access(logic [OP_W-1:0] op,
                                                  logic [KEY_W-1:0] key,
                                                  logic [PAYLOAD_W-1:0] data);
    cache_outcome_t r;
    int idx;
    r = '{default: 0};
    idx = slot_of(key);
    case (op)
      OP_LOOKUP, OP_INSERT: begin
        if (!enable_shadow) begin
          misses_total++;
        end else begin
          if (slot_live[idx] && slot_key[idx] == key) begin
            hits_total++;
            r.hit = 1'b1;
            r.payload_out = slot_data[idx];
          end else begin
            misses_total++;
            if (slot_live[idx]) begin
              collisions_total++;
              r.collision = 1'b1;
            end
          end
          if (op == OP_INSERT) begin
            slot_live[idx] = 1'b1;
            slot_key[idx] = key;
            slot_data[idx] = data;
            r.stored = 1'b1;
            r.payload_out = data;
          end
        end
      end
      OP_FILL: begin
        if (enable_shadow) begin
          slot_live[idx] = 1'b1;
          slot_key[idx] = key;
          slot_data[idx] = data;
          r.stored = 1'b1;
          r.payload_out = data;
        end
      end
      default: ;
    endcase
    r.hits = hits_total;
    r.misses = misses_total;
    r.collisions = collisions_total;
    return r;
  endfunction

  // Offer one request after a random gap and record its response
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [PAYLOAD_W-1:0] data);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    opcode = key;
    payload = data;
    do @(posedge clk); while (in_stall !== 1'b0);
    last_outcome = cache_access(op, key, data);
    outcomes_due.push_back(last_outcome);
    if (op != OP_UNUSED) requests_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every owed response has come back
  task automatic wait_for_outcomes;
    in_valid = 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_enable(input bit value);
    wait_for_outcomes();
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    enable_shadow = value;
    enable_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pool_key;
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Corner keys and payloads, every operation, collisions, ignored code
  task automatic test_directed_corners;
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    do
      ka = $urandom;
    while (slot_of(ka) == slot_of('0) || slot_of(ka) == slot_of('1));
    kb = partner_of(ka);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    send_request(OP_LOOKUP, '0, '1);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_LOOKUP, '0, '1);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_INSERT, '1, 64'h5a5a_a5a5_0f0f_f0f0);
    send_request(OP_FILL, ka, {$urandom, $urandom});
    send_request(OP_LOOKUP, kb, '0);
    send_request(OP_INSERT, kb, {$urandom, $urandom});
    send_request(OP_LOOKUP, ka, '0);
    send_request(OP_FILL, ka, '1);
    send_request(OP_LOOKUP, ka, '0);
    send_request(OP_UNUSED, '0, '1);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_FILL, '1, '0);
    send_request(OP_LOOKUP, '1, '1);
  endtask

  // With the table off: count misses, store nothing, then check it stayed empty
  task automatic test_cache_disabled;
    logic [KEY_W-1:0] fresh;
    do
      fresh = $urandom;
    while (slot_live[slot_of(fresh)]);
    write_enable(1'b0);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_INSERT, fresh, '1);
    send_request(OP_FILL, fresh, '1);
    send_request(OP_UNUSED, fresh, '1);
    send_request(OP_LOOKUP, fresh, '0);
    write_enable(1'b1);
    send_request(OP_LOOKUP, fresh, '0);
    send_request(OP_LOOKUP, '0, '1);
  endtask

  // Stall the output for a long stretch while requests keep coming
  task automatic test_output_backpressure;
    logic [OP_W-1:0] op;
    wait_for_outcomes();
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      op = OP_W'($urandom_range(0, 2));
      op = (op == OP_UNUSED) ? OP_LOOKUP : op;
      send_request(op, pool_key(), {$urandom, $urandom});
      // pause the sender midway until the pipe is empty
      if (i == 19) wait_for_outcomes();
    end
    wait_for_outcomes();
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Tracer-like traffic on a small key pool, with one disabled segment
  task automatic test_random_traffic;
    int counted;
    int pick;
    logic [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0] data;
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 4) write_enable(1'b0);
      if (seg == 5) write_enable(1'b1);
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < 50) begin
        key = pool_key();
        data = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // look up, fill on miss
          send_request(OP_LOOKUP, key, data);
          counted++;
          if (!last_outcome.hit) begin
            send_request(OP_FILL, key, data);
            counted++;
          end
        end else if (pick < 65) begin
          send_request(OP_INSERT, key, data);
          counted++;
        end else if (pick < 80) begin
          send_request(OP_LOOKUP, key, data);
          counted++;
        end else if (pick < 95) begin
          send_request(OP_FILL, key, data);
          counted++;
        end else begin
          send_request(OP_UNUSED, key, data);
        end
      end
    end
  endtask

  // Output side: random stalls per response, plus an occasional long hold
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = rx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        long_holds++;
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1 || rst);
      @(negedge clk);
    end
  end

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check each accepted response against the oldest owed one
  always @(posedge clk) begin : response_check
    cache_outcome_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: response with no request outstanding", $time);
        errors++;
      end else begin
        want = outcomes_due.pop_front();
        compare_field("hit", want.hit, hit);
        compare_field("collision", want.collision, collision);
        compare_field("stored", want.stored, stored);
        compare_field("payload_out", want.payload_out, payload_out);
        compare_field("hit_count", want.hits, hit_count);
        compare_field("miss_count", want.misses, miss_count);
        compare_field("collision_count", want.collisions, collision_count);
        results_checked++;
        if (want.hit) hits_checked++;
        if (want.collision) collisions_checked++;
        if (want.stored) stores_checked++;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    operation = OP_LOOKUP;
    opcode = '0;
    payload = '0;
    enable_shadow = 1'b1;
    rx_hold_cycles = 0;
    // colliding key pairs plus the two extreme keys
    for (int i = 0; i < POOL_SIZE - 2; i += 2) begin
      key_pool[i] = $urandom;
      key_pool[i + 1] = partner_of(key_pool[i]);
    end
    key_pool[POOL_SIZE - 2] = '0;
    key_pool[POOL_SIZE - 1] = '1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_corners();
    test_cache_disabled();
    test_output_backpressure();
    test_random_traffic();

    wait_for_outcomes();
    repeat (4 * LATENCY) @(negedge clk);
    $display("Covered %0d requests: %0d responses checked, %0d hits, %0d collisions, %0d stores",
             requests_sent, results_checked, hits_checked, collisions_checked, stores_checked);
    $display("Enable register written %0d times; output held off for long %0d time(s)",
             enable_writes, long_holds);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
